>>> sv/rbst_pkg.sv
// Shared constants and types for the ray against box slab test block.
`default_nettype none

package rbst_pkg;

	// Width of the configuration register index.
	localparam int unsigned CFG_IDX_W = 3;

	// Configuration register map.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X  = 3'd0,
		CFG_ORIGIN_Y  = 3'd1,
		CFG_ORIGIN_Z  = 3'd2,
		CFG_INV_DIR_X = 3'd3,
		CFG_INV_DIR_Y = 3'd4,
		CFG_INV_DIR_Z = 3'd5,
		CFG_T_START   = 3'd6,
		CFG_T_END     = 3'd7
	} cfg_idx_t;

	// Number of axes tested per box.
	localparam int unsigned NUM_AXES = 3;

	// Cycles from an accepted transaction to its result strobe.
	localparam int unsigned PIPE_DEPTH = 6;

endpackage

`default_nettype wire

>>> sv/rbst_cfg_regs.sv
// Configuration register file holding the ray set-up.
`default_nettype none

module rbst_cfg_regs #(
	parameter int unsigned COORD_WIDTH = 32,
	parameter int unsigned FRAC_BITS   = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire rbst_pkg::cfg_idx_t            cfg_idx,
	input  wire logic [COORD_WIDTH-1:0]        cfg_wdata,
	output logic signed [COORD_WIDTH-1:0]      origin_q   [rbst_pkg::NUM_AXES],
	output logic signed [COORD_WIDTH-1:0]      inv_dir_q  [rbst_pkg::NUM_AXES],
	output logic signed [COORD_WIDTH-1:0]      t_start_q,
	output logic signed [COORD_WIDTH-1:0]      t_end_q
);
	import rbst_pkg::*;

	localparam logic [COORD_WIDTH-1:0] ONE     = COORD_WIDTH'(1) << FRAC_BITS;
	localparam logic [COORD_WIDTH-1:0] POS_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				origin_q[i]  <= '0;
				inv_dir_q[i] <= ONE;
			end
			t_start_q <= '0;
			t_end_q   <= POS_MAX;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_ORIGIN_X:  origin_q[0]  <= cfg_wdata;
				CFG_ORIGIN_Y:  origin_q[1]  <= cfg_wdata;
				CFG_ORIGIN_Z:  origin_q[2]  <= cfg_wdata;
				CFG_INV_DIR_X: inv_dir_q[0] <= cfg_wdata;
				CFG_INV_DIR_Y: inv_dir_q[1] <= cfg_wdata;
				CFG_INV_DIR_Z: inv_dir_q[2] <= cfg_wdata;
				CFG_T_START:   t_start_q    <= cfg_wdata;
				CFG_T_END:     t_end_q      <= cfg_wdata;
				default:       t_end_q      <= t_end_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/rbst_axis.sv
// Per-axis slab distance pipeline: difference, product, scale and order.
`default_nettype none

module rbst_axis #(
	parameter int unsigned COORD_WIDTH = 32,
	parameter int unsigned FRAC_BITS   = 16
) (
	input  wire logic                          clk,
	input  wire logic signed [COORD_WIDTH-1:0] box_lo,
	input  wire logic signed [COORD_WIDTH-1:0] box_hi,
	input  wire logic signed [COORD_WIDTH-1:0] origin,
	input  wire logic signed [COORD_WIDTH-1:0] inv_dir,
	output logic signed [COORD_WIDTH-1:0]      near_s3,
	output logic signed [COORD_WIDTH-1:0]      far_s3,
	output logic                               outside_s3
);
	localparam int unsigned DW = COORD_WIDTH + 1;
	localparam int unsigned PW = 2 * COORD_WIDTH + 1;
	localparam logic signed [COORD_WIDTH-1:0] POS_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] NEG_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic signed [DW-1:0]          dlo_s1, dhi_s1;
	logic signed [PW-1:0]          plo_s2, phi_s2;
	logic                          par_s2, outside_s2;
	logic signed [COORD_WIDTH-1:0] slo, shi;

	// Drop the fraction bits (a floor, since the shift is arithmetic) and clamp.
	function automatic logic signed [COORD_WIDTH-1:0] scale_sat(input logic signed [PW-1:0] p);
		logic signed [PW-1:0]      sh;
		logic [PW-COORD_WIDTH:0]   top;
		sh  = p >>> FRAC_BITS;
		top = sh[PW-1:COORD_WIDTH-1];
		if ((&top) || !(|top))
			return sh[COORD_WIDTH-1:0];
		else if (sh[PW-1])
			return NEG_MIN;
		else
			return POS_MAX;
	endfunction

	// Stage 1: exact differences from the origin.
	always_ff @(posedge clk) begin
		dlo_s1 <= DW'(box_lo) - DW'(origin);
		dhi_s1 <= DW'(box_hi) - DW'(origin);
	end

	// Stage 2: full-width products and the parallel-axis containment check.
	always_ff @(posedge clk) begin
		plo_s2     <= PW'(dlo_s1) * PW'(inv_dir);
		phi_s2     <= PW'(dhi_s1) * PW'(inv_dir);
		par_s2     <= (inv_dir == '0);
		outside_s2 <= (inv_dir == '0) && ((dlo_s1 > 0) || (dhi_s1 < 0));
	end

	assign slo = scale_sat(plo_s2);
	assign shi = scale_sat(phi_s2);

	// Stage 3: order the two distances; a parallel axis leaves the interval open.
	always_ff @(posedge clk) begin
		outside_s3 <= outside_s2;
		if (par_s2) begin
			near_s3 <= NEG_MIN;
			far_s3  <= POS_MAX;
		end else if (slo > shi) begin
			near_s3 <= shi;
			far_s3  <= slo;
		end else begin
			near_s3 <= slo;
			far_s3  <= shi;
		end
	end

endmodule

`default_nettype wire

>>> sv/rbst_merge.sv
// Interval narrowing over three axes and the final hit decision.
`default_nettype none

module rbst_merge #(
	parameter int unsigned COORD_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic signed [COORD_WIDTH-1:0] t_start,
	input  wire logic signed [COORD_WIDTH-1:0] t_end,
	input  wire logic signed [COORD_WIDTH-1:0] near_s3    [rbst_pkg::NUM_AXES],
	input  wire logic signed [COORD_WIDTH-1:0] far_s3     [rbst_pkg::NUM_AXES],
	input  wire logic                          outside_s3 [rbst_pkg::NUM_AXES],
	output logic                               hit_s6,
	output logic signed [COORD_WIDTH-1:0]      t_enter_s6,
	output logic signed [COORD_WIDTH-1:0]      t_exit_s6
);
	import rbst_pkg::*;

	logic signed [COORD_WIDTH-1:0] lo_a_s4, lo_b_s4, hi_a_s4, hi_b_s4;
	logic signed [COORD_WIDTH-1:0] t0_s5, t1_s5;
	logic                          miss_s4, miss_s5;

	// Stage 4: first level of the max and min trees.
	always_ff @(posedge clk) begin
		lo_a_s4 <= (near_s3[0] > t_start) ? near_s3[0] : t_start;
		lo_b_s4 <= (near_s3[1] > near_s3[2]) ? near_s3[1] : near_s3[2];
		hi_a_s4 <= (far_s3[0] < t_end) ? far_s3[0] : t_end;
		hi_b_s4 <= (far_s3[1] < far_s3[2]) ? far_s3[1] : far_s3[2];
		miss_s4 <= outside_s3[0] | outside_s3[1] | outside_s3[2];
	end

	// Stage 5: final entry and exit parameters.
	always_ff @(posedge clk) begin
		t0_s5   <= (lo_a_s4 > lo_b_s4) ? lo_a_s4 : lo_b_s4;
		t1_s5   <= (hi_a_s4 < hi_b_s4) ? hi_a_s4 : hi_b_s4;
		miss_s5 <= miss_s4;
	end

	// Stage 6: result register; a miss reports zero parameters.
	always_ff @(posedge clk) begin
		if (!miss_s5 && (t0_s5 <= t1_s5)) begin
			hit_s6     <= 1'b1;
			t_enter_s6 <= t0_s5;
			t_exit_s6  <= t1_s5;
		end else begin
			hit_s6     <= 1'b0;
			t_enter_s6 <= '0;
			t_exit_s6  <= '0;
		end
	end

endmodule

`default_nettype wire

>>> sv/ray_box_slab_test_core.sv
// Top level of the streaming ray against axis-aligned box slab test.
`default_nettype none

// Software first writes the ray through the configuration port: the origin,
// the reciprocal of each direction component (zero marks an axis parallel to
// the ray) and the parameter interval [t_start, t_end], all signed fixed point
// with FRAC_BITS fraction bits. Boxes then stream in as their lower and upper
// corners, one transaction per clock cycle if wanted; busy is always low since
// nothing in the pipeline can stall. Each accepted box produces exactly one
// result transaction, marked by done for a single cycle, in the order the
// boxes arrived. The receiver cannot hold results off, so it must take each
// one as it appears. Each result passes through six register stages: origin
// difference, the full-width multiply per slab, scaling with saturation and
// ordering of the two distances, and two levels of the max/min tree followed
// by the result register. Configuration must only be written while no box
// transaction is in flight, i.e. after the result strobe of the last accepted
// box. On a miss hit is low and both parameters are zero.
module ray_box_slab_test_core #(
	parameter int unsigned COORD_WIDTH = 32,
	parameter int unsigned FRAC_BITS   = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Configuration write port.
	input  wire logic                            cfg_we,
	input  wire logic [rbst_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [COORD_WIDTH-1:0]          cfg_wdata,
	// Box transactions.
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic signed [COORD_WIDTH-1:0]   box_min_x,
	input  wire logic signed [COORD_WIDTH-1:0]   box_min_y,
	input  wire logic signed [COORD_WIDTH-1:0]   box_min_z,
	input  wire logic signed [COORD_WIDTH-1:0]   box_max_x,
	input  wire logic signed [COORD_WIDTH-1:0]   box_max_y,
	input  wire logic signed [COORD_WIDTH-1:0]   box_max_z,
	// Result transactions.
	output logic                                 done,
	output logic                                 hit,
	output logic signed [COORD_WIDTH-1:0]        t_enter,
	output logic signed [COORD_WIDTH-1:0]        t_exit
);
	import rbst_pkg::*;

	logic signed [COORD_WIDTH-1:0] origin_q  [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] inv_dir_q [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] t_start_q, t_end_q;

	logic signed [COORD_WIDTH-1:0] box_lo [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] box_hi [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] near_s3 [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] far_s3  [NUM_AXES];
	logic                          outside_s3 [NUM_AXES];

	logic accept;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	// The pipeline advances every cycle, so a new box is always welcome.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	assign box_lo[0] = box_min_x;
	assign box_lo[1] = box_min_y;
	assign box_lo[2] = box_min_z;
	assign box_hi[0] = box_max_x;
	assign box_hi[1] = box_max_y;
	assign box_hi[2] = box_max_z;

	rbst_cfg_regs #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx_t'(cfg_idx)),
		.cfg_wdata (cfg_wdata),
		.origin_q  (origin_q),
		.inv_dir_q (inv_dir_q),
		.t_start_q (t_start_q),
		.t_end_q   (t_end_q)
	);

	// One slab pipeline per axis; the data registers run freely and only the
	// valid bits below decide which results are real.
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		rbst_axis #(
			.COORD_WIDTH (COORD_WIDTH),
			.FRAC_BITS   (FRAC_BITS)
		) u_axis (
			.clk        (clk),
			.box_lo     (box_lo[a]),
			.box_hi     (box_hi[a]),
			.origin     (origin_q[a]),
			.inv_dir    (inv_dir_q[a]),
			.near_s3    (near_s3[a]),
			.far_s3     (far_s3[a]),
			.outside_s3 (outside_s3[a])
		);
	end

	rbst_merge #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_merge (
		.clk        (clk),
		.t_start    (t_start_q),
		.t_end      (t_end_q),
		.near_s3    (near_s3),
		.far_s3     (far_s3),
		.outside_s3 (outside_s3),
		.hit_s6     (hit),
		.t_enter_s6 (t_enter),
		.t_exit_s6  (t_exit)
	);

	// The valid bits follow each transaction down the six stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	assign done = valid_s6;

	// Every accepted box yields its result strobe after the full pipeline depth.
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(PIPE_DEPTH) done)
		else $error("accepted box did not produce a result in time");

	// A result strobe is never produced without a box accepted earlier.
	a_no_phantom : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, PIPE_DEPTH))
		else $error("result strobe without an accepted box");

	// A miss carries zero parameters.
	a_miss_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (t_enter == '0) && (t_exit == '0))
		else $error("miss with non-zero parameters");

	// A hit always reports an ordered, non-empty interval.
	a_hit_order : assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> (t_enter <= t_exit))
		else $error("hit with entry after exit");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the ray against axis-aligned box slab test core.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rbst_pkg::*;

	// The core is used at its default size: signed Q16.16 coordinates.
	localparam int CW = 32;
	localparam int FB = 16;
	// A slab product needs 2*CW+1 bits; one spare bit keeps the sign safe.
	localparam int WW = 2 * CW + 2;

	// Generous bound on the run.
	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned BOXES_PER_PHASE = 75;

	typedef logic signed [CW-1:0] coord_t;

	localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam coord_t ONE = coord_t'(1) << FB;

	// One box transaction, as it appears on the input ports.
	typedef struct packed {
		coord_t min_x;
		coord_t min_y;
		coord_t min_z;
		coord_t max_x;
		coord_t max_y;
		coord_t max_z;
	} box_t;

	// One result transaction.
	typedef struct packed {
		logic   hit;
		coord_t t_enter;
		coord_t t_exit;
	} slab_res_t;

	// The whole ray, indexed by configuration register.
	typedef coord_t ray_t [8];

	// The scoreboard keeps its own copy of the ray registers, predicts the
	// outcome of every accepted box and checks results strictly in order,
	// since the core returns them in arrival order.
	class slab_scoreboard;
		coord_t      ray_cfg [8];
		slab_res_t   expected_hits [$];
		int unsigned mismatches;

		function new();
			ray_cfg[CFG_ORIGIN_X]  = '0;
			ray_cfg[CFG_ORIGIN_Y]  = '0;
			ray_cfg[CFG_ORIGIN_Z]  = '0;
			ray_cfg[CFG_INV_DIR_X] = ONE;
			ray_cfg[CFG_INV_DIR_Y] = ONE;
			ray_cfg[CFG_INV_DIR_Z] = ONE;
			ray_cfg[CFG_T_START]   = '0;
			ray_cfg[CFG_T_END]     = COORD_MAX;
			mismatches = 0;
		endfunction

		function void note_config(cfg_idx_t idx, coord_t value);
			ray_cfg[idx] = value;
		endfunction

		// Distance to one slab plane: the exact product of the widened
		// difference and the reciprocal, floored by the arithmetic shift and
		// then clamped to the coordinate range.
		function coord_t slab_distance(coord_t corner, coord_t org, coord_t inv);
			logic signed [WW-1:0] span;
			logic signed [WW-1:0] scaled;
			span = corner - org;
			scaled = (span * inv) >>> FB;
			if (scaled > COORD_MAX)
				return COORD_MAX;
			if (scaled < COORD_MIN)
				return COORD_MIN;
			return scaled[CW-1:0];
		endfunction

		function slab_res_t intersect_box(box_t b);
			coord_t    lo [3];
			coord_t    hi [3];
			coord_t    org, inv, t_near, t_far, t_in, t_out;
			logic      miss;
			int        a;
			slab_res_t r;
			lo = '{b.min_x, b.min_y, b.min_z};
			hi = '{b.max_x, b.max_y, b.max_z};
			t_in = ray_cfg[CFG_T_START];
			t_out = ray_cfg[CFG_T_END];
			miss = 1'b0;
			for (a = 0; a < NUM_AXES; a++) begin
				org = ray_cfg[int'(CFG_ORIGIN_X) + a];
				inv = ray_cfg[int'(CFG_INV_DIR_X) + a];
				if (inv == '0) begin
					// Parallel axis: only the origin's position counts.
					if (org < lo[a] || org > hi[a])
						miss = 1'b1;
				end else begin
					t_near = slab_distance(lo[a], org, inv);
					t_far = slab_distance(hi[a], org, inv);
					if (t_near > t_far) begin
						t_near = t_far;
						t_far = slab_distance(lo[a], org, inv);
					end
					if (t_near > t_in)
						t_in = t_near;
					if (t_far < t_out)
						t_out = t_far;
				end
			end
			if (t_in > t_out)
				miss = 1'b1;
			if (miss)
				r = '{hit: 1'b0, t_enter: '0, t_exit: '0};
			else
				r = '{hit: 1'b1, t_enter: t_in, t_exit: t_out};
			return r;
		endfunction

		function void note_box(box_t b);
			expected_hits.push_back(intersect_box(b));
		endfunction

		function int pending();
			return expected_hits.size();
		endfunction

		function void check_result(slab_res_t got);
			slab_res_t want;
			if (expected_hits.size() == 0) begin
				$display("%0t: result with none expected: hit %0b t_enter %0d t_exit %0d",
					$time, got.hit, got.t_enter, got.t_exit);
				mismatches++;
				return;
			end
			want = expected_hits.pop_front();
			if (got !== want) begin
				mismatches++;
				if (got.hit !== want.hit)
					$display("%0t: hit mismatch: expected %0b, actual %0b",
						$time, want.hit, got.hit);
				if (got.t_enter !== want.t_enter)
					$display("%0t: t_enter mismatch: expected %0d, actual %0d",
						$time, want.t_enter, got.t_enter);
				if (got.t_exit !== want.t_exit)
					$display("%0t: t_exit mismatch: expected %0d, actual %0d",
						$time, want.t_exit, got.t_exit);
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     cfg_we;
	cfg_idx_t cfg_idx;
	coord_t   cfg_wdata;
	logic     start;
	logic     busy;
	coord_t   box_min_x, box_min_y, box_min_z;
	coord_t   box_max_x, box_max_y, box_max_z;
	logic     done;
	logic     hit;
	coord_t   t_enter, t_exit;

	slab_scoreboard sb = new();
	int unsigned    cycle_count = 0;

	ray_box_slab_test_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Everything the core does is observed at the rising edge, where the
	// values seen are those from before the edge: configuration writes, box
	// transactions accepted with start high and busy low, and result strobes.
	// Inputs are noted before results so that ordering would still hold for
	// a core with no register stages at all.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (cfg_we)
				sb.note_config(cfg_idx, cfg_wdata);
			if (start && !busy)
				sb.note_box(box_t'{box_min_x, box_min_y, box_min_z,
					box_max_x, box_max_y, box_max_z});
			if (done)
				sb.check_result(slab_res_t'{hit, t_enter, t_exit});
		end
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Presents one box and holds it until the core takes the transaction.
	// The caller is always at a rising edge, so start is raised at most once
	// per time step and is left high for a back-to-back follower.
	task automatic send_box(input box_t b);
		start <= 1'b1;
		box_min_x <= b.min_x;
		box_min_y <= b.min_y;
		box_min_z <= b.min_z;
		box_max_x <= b.max_x;
		box_max_y <= b.max_y;
		box_max_z <= b.max_z;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	// Idles the sender for a random number of cycles, each one with the
	// given chance in a hundred.
	task automatic sender_gap(input int unsigned idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stops sending and waits until every outstanding result has come back.
	// Every box yields exactly one result, so an empty queue means the
	// pipeline holds nothing and the ray registers may be changed.
	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// Writes every ray register, one per cycle, in index order.
	task automatic load_ray(input ray_t r);
		cfg_idx_t idx;
		idx = idx.first();
		do begin
			cfg_we <= 1'b1;
			cfg_idx <= idx;
			cfg_wdata <= r[idx];
			@(posedge clk);
			idx = idx.next();
		end while (idx != idx.first());
		cfg_we <= 1'b0;
	endtask

	function automatic box_t cube(input coord_t lo, input coord_t hi);
		return '{lo, lo, lo, hi, hi, hi};
	endfunction

	function automatic int signed_span(input int unsigned span);
		return int'($urandom_range(2 * span)) - int'(span);
	endfunction

	// A random ray. Mostly modest values, so that boxes near the origin are
	// often hit, with a share of full-range values, extremes, parallel axes
	// and empty intervals.
	function automatic ray_t random_ray();
		ray_t        r;
		int unsigned k;
		int          a;
		for (a = 0; a < NUM_AXES; a++) begin
			k = $urandom_range(99);
			if (k < 70)
				r[int'(CFG_ORIGIN_X) + a] = coord_t'(signed_span(1 << 20));
			else if (k < 85)
				r[int'(CFG_ORIGIN_X) + a] = coord_t'($urandom());
			else
				r[int'(CFG_ORIGIN_X) + a] = $urandom_range(1) ? COORD_MAX : COORD_MIN;
			k = $urandom_range(99);
			if (k < 15)
				r[int'(CFG_INV_DIR_X) + a] = '0;
			else if (k < 65)
				r[int'(CFG_INV_DIR_X) + a] = $urandom_range(1)
					? coord_t'($urandom_range(1 << 18, 1))
					: -coord_t'($urandom_range(1 << 18, 1));
			else if (k < 80)
				r[int'(CFG_INV_DIR_X) + a] = coord_t'($urandom());
			else if (k < 90)
				r[int'(CFG_INV_DIR_X) + a] = $urandom_range(1) ? COORD_MAX : COORD_MIN;
			else
				r[int'(CFG_INV_DIR_X) + a] = $urandom_range(1) ? ONE : -ONE;
		end
		k = $urandom_range(99);
		if (k < 50)
			r[CFG_T_START] = '0;
		else if (k < 70)
			r[CFG_T_START] = -coord_t'($urandom_range(1 << 22));
		else if (k < 85)
			r[CFG_T_START] = coord_t'($urandom());
		else
			r[CFG_T_START] = COORD_MIN;
		k = $urandom_range(99);
		if (k < 50)
			r[CFG_T_END] = COORD_MAX;
		else if (k < 75)
			r[CFG_T_END] = coord_t'($urandom_range(1 << 24));
		else
			r[CFG_T_END] = coord_t'($urandom());
		return r;
	endfunction

	// A random box for the given ray. Boxes that enclose the origin are
	// nearly always hit; boxes placed near it give both hits and misses;
	// the rest are full-range noise and boxes with corners swapped.
	function automatic box_t random_box(input ray_t r);
		coord_t      lo [3];
		coord_t      hi [3];
		coord_t      org, swap_tmp;
		int unsigned k;
		int          a;
		k = $urandom_range(99);
		for (a = 0; a < NUM_AXES; a++) begin
			org = r[int'(CFG_ORIGIN_X) + a];
			if (k < 40) begin
				lo[a] = org - coord_t'($urandom_range(1 << 18));
				hi[a] = org + coord_t'($urandom_range(1 << 18));
			end else if (k < 70 || k >= 85) begin
				lo[a] = org + coord_t'(signed_span(1 << 19));
				hi[a] = lo[a] + coord_t'($urandom_range(1 << 18));
				if (k >= 85 && $urandom_range(1)) begin
					swap_tmp = lo[a];
					lo[a] = hi[a];
					hi[a] = swap_tmp;
				end
			end else begin
				lo[a] = coord_t'($urandom());
				hi[a] = coord_t'($urandom());
			end
		end
		return '{lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
	endfunction

	initial begin
		ray_t        ray;
		int unsigned idle_pct;
		int unsigned phase;
		int unsigned n;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= CFG_ORIGIN_X;
		cfg_wdata <= '0;
		start <= 1'b0;
		box_min_x <= '0;
		box_min_y <= '0;
		box_min_z <= '0;
		box_max_x <= '0;
		box_max_y <= '0;
		box_max_z <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, back to back. First the ray left by reset: origin
		// at zero, unit direction, interval from zero to the largest value.
		send_box(cube(ONE, 2 * ONE));
		send_box(cube(-ONE, ONE));
		send_box(cube(-3 * ONE, -2 * ONE));
		send_box(cube(COORD_MIN, COORD_MAX));
		send_box(cube(COORD_MAX, COORD_MAX));
		send_box(cube(2 * ONE, ONE));
		send_box(cube('0, '0));

		// Origin at the most negative corner with the largest reciprocal:
		// the widest difference and a product that must saturate.
		drain();
		load_ray('{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MIN, COORD_MAX});
		send_box(cube(COORD_MIN, COORD_MAX));
		send_box(cube(COORD_MIN + 1, COORD_MIN + 1));

		// The opposite: origin at the top, most negative reciprocal.
		drain();
		load_ray('{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MAX});
		send_box(cube(COORD_MIN, COORD_MAX));
		send_box(cube('0, '0));
		send_box(cube(COORD_MAX - 1, COORD_MAX - 1));

		// A negative fractional reciprocal on x, so that flooring of
		// negative products with a remainder is seen; y parallel to the ray
		// with the origin inside, outside, on either face and in a box with
		// swapped corners; a tiny reciprocal on z.
		drain();
		load_ray('{coord_t'(19661), '0, ONE, coord_t'(-49152), '0, coord_t'(3),
			-100 * ONE, COORD_MAX});
		send_box('{-5 * ONE + 7, -ONE, ONE - 5, 3 * ONE - 1, ONE, 4 * ONE + 123});
		send_box('{-5 * ONE + 7, coord_t'(1), ONE - 5, 3 * ONE - 1, ONE, 4 * ONE + 123});
		send_box('{-5 * ONE + 7, '0, ONE - 5, 3 * ONE - 1, '0, 4 * ONE + 123});
		send_box('{-5 * ONE + 7, ONE, ONE - 5, 3 * ONE - 1, -ONE, 4 * ONE + 123});
		send_box('{-5 * ONE + 7, -ONE, ONE - 5, 3 * ONE - 1, '0, 4 * ONE + 123});

		// An interval of a single point, which is still hit.
		drain();
		load_ray('{'0, '0, '0, ONE, ONE, ONE, ONE, ONE});
		send_box(cube('0, 2 * ONE));

		// An empty interval misses every box.
		drain();
		load_ray('{'0, '0, '0, ONE, ONE, ONE, 2 * ONE, ONE});
		send_box(cube(-4 * ONE, 4 * ONE));

		// All three axes parallel: the interval passes through unchanged.
		drain();
		load_ray('{'0, '0, '0, '0, '0, '0, COORD_MIN, COORD_MAX});
		send_box(cube(-ONE, ONE));
		send_box(cube(ONE, 2 * ONE));

		// Random part. Each phase loads a fresh ray while the core is idle
		// and then streams boxes under one idling pattern. The receiver
		// cannot hold results off, so no phase stalls it; the even phases run without gaps.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase % 4)
				1: idle_pct = 73;
				3: idle_pct = 22;
				default: idle_pct = 0;
			endcase
			drain();
			ray = random_ray();
			load_ray(ray);
			for (n = 0; n < BOXES_PER_PHASE; n++) begin
				// Now and then the sender waits for every result mid-phase.
				if ($urandom_range(59) == 0)
					drain();
				sender_gap(idle_pct);
				send_box(random_box(ray));
			end
		end

		drain();
		repeat (PIPE_DEPTH + 4) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
